FILE: src/isr64_pkg.sv
`timescale 1ns / 1ps
// Shared constants, state encoding and control types for the 64-bit integer square root.
package isr64_pkg;

    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    // The shifted remainder needs two bits more than the stored one, which needs ROOT_W + 1.
    localparam int CHAIN_W = ROOT_W + 3;
    localparam int CNT_W   = $clog2(ROOT_W);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROOT_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } cell_ctrl_t;

endpackage

FILE: src/integer_square_root_64_core.sv
`timescale 1ns / 1ps
// Top level of the 64-bit floor square root: handshake, step sequencer and result register.
//
//   Channel  Handshake             Payload
//   -------  --------------------  -------------------------------
//   input    in_valid / in_ready   radicand [63:0], unsigned
//   output   out_valid / out_ready root [31:0], unsigned, floor root
//
// An accepted item loads the 35-cell row, which then runs 32 steps, one root bit per
// step, each step one ripple subtract across the row. From the done state the root moves
// into the output register once that register is free, and the next item can be taken at
// that same edge, so a new item is never taken while one is still running.
// A stalled output holds the finished root in the cell row and keeps in_ready low until
// the output register frees up. Reset clears the sequencer and the output valid flag.
module integer_square_root_64_core
    import isr64_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [RAD_W-1:0]  radicand,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ROOT_W-1:0] root
);

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [RAD_W-1:0]  rad_reg;
    logic [RAD_W-1:0]  rad_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;

    cell_ctrl_t        ctrl;
    logic              capture;
    logic              in_fire;
    logic              out_free;
    logic [ROOT_W-1:0] chain_root;

    assign out_free = ~out_valid_reg | out_ready;
    assign in_fire  = in_valid & in_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = in_valid ? ST_RUN : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs. The cells load on every accepted item and step while running.
    always_comb
    begin
        in_ready  = 1'b0;
        capture   = 1'b0;
        ctrl.step = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_RUN:
            begin
                ctrl.step = 1'b1;
            end
            ST_DONE:
            begin
                in_ready = out_free;
                capture  = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        ctrl.load = in_fire;
    end

    // Step counter and radicand shift register; the top pair of bits feeds the cell row.
    always_comb
    begin
        cnt_next = cnt_reg;
        rad_next = rad_reg;
        if (in_fire)
        begin
            cnt_next = '0;
            rad_next = radicand;
        end
        else if (ctrl.step)
        begin
            cnt_next = cnt_reg + 1'b1;
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
        end
    end

    // Output register: it takes the finished root whenever it is empty or being drained.
    always_comb
    begin
        root_next      = root_reg;
        out_valid_next = out_valid_reg;
        if (capture)
        begin
            root_next      = chain_root;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
    end

    isr64_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .pair  (rad_reg[RAD_W-1:RAD_W-2]),
        .root  (chain_root)
    );

    assign out_valid = out_valid_reg;
    assign root      = root_reg;

endmodule

FILE: src/isr64_cell.sv
`timescale 1ns / 1ps
// One bit slice of the square root datapath: a remainder bit, a root bit and a borrow stage.
module isr64_cell
    import isr64_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       take,
    input  logic       shift_bit,
    input  logic       trial_bit,
    input  logic       borrow_in,
    input  logic       root_in,
    output logic       rem_bit,
    output logic       root_bit,
    output logic       borrow_out
);

    logic rem_reg;
    logic rem_next;
    logic root_reg;
    logic root_next;
    logic diff;

    // One position of the ripple subtract of the trial value from the shifted remainder.
    assign diff       = shift_bit ^ trial_bit ^ borrow_in;
    assign borrow_out = (~shift_bit & trial_bit) | (~(shift_bit ^ trial_bit) & borrow_in);

    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        if (ctrl.load)
        begin
            rem_next  = 1'b0;
            root_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            rem_next  = take ? diff : shift_bit;
            root_next = root_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= 1'b0;
            root_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_bit  = rem_reg;
    assign root_bit = root_reg;

endmodule

FILE: src/isr64_chain.sv
`timescale 1ns / 1ps
// Row of bit-slice cells that settles one root bit per step.
module isr64_chain
    import isr64_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctrl_t        ctrl,
    input  logic [1:0]        pair,
    output logic [ROOT_W-1:0] root
);

    logic [CHAIN_W-1:0] rem_w;
    logic [CHAIN_W-1:0] root_w;
    logic [CHAIN_W-1:0] shift_w;
    logic [CHAIN_W-1:0] trial_w;
    logic [CHAIN_W-1:0] root_in_w;
    logic [CHAIN_W:0]   borrow_w;
    logic               take;

    assign borrow_w[0] = 1'b0;
    // No borrow out of the top means the shifted remainder is at least the trial value.
    assign take = ~borrow_w[CHAIN_W];

    genvar j;
    generate
        for (j = 0; j < CHAIN_W; j++)
        begin : g_cell
            if (j < 2)
            begin : g_low
                assign shift_w[j] = pair[j];
                assign trial_w[j] = (j == 0) ? 1'b1 : 1'b0;
            end
            else
            begin : g_high
                assign shift_w[j] = rem_w[j-2];
                assign trial_w[j] = root_w[j-2];
            end

            if (j == 0)
            begin : g_first
                assign root_in_w[j] = take;
            end
            else
            begin : g_rest
                assign root_in_w[j] = root_w[j-1];
            end

            isr64_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .take       (take),
                .shift_bit  (shift_w[j]),
                .trial_bit  (trial_w[j]),
                .borrow_in  (borrow_w[j]),
                .root_in    (root_in_w[j]),
                .rem_bit    (rem_w[j]),
                .root_bit   (root_w[j]),
                .borrow_out (borrow_w[j+1])
            );
        end
    endgenerate

    assign root = root_w[ROOT_W-1:0];

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 64-bit floor square root core.
module testbench;
    import isr64_pkg::*;

    // The run is ended here if results stop coming. The slowest correct run is
    // about 1100 items, plus random sender gaps and receiver stalls, and this
    // limit is several times that.
    localparam int CYCLE_LIMIT   = 400000;
    // Quiet time at the end, a little more than one item's trip through the core.
    localparam int TAIL_CYCLES   = 40;
    localparam int ITEMS_A_PHASE = 258;
    localparam int MAX_PRINTED   = 100;

    // Keeps the roots owed by the core, oldest first, and checks each result
    // against the head of that queue.
    class sqrt_scoreboard;
        logic [ROOT_W-1:0] expected_roots[$];
        int errors = 0;

        // Builds the root one bit at a time from the top: a bit stays set only
        // when the square of the partial root still fits under the radicand.
        static function logic [ROOT_W-1:0] floor_sqrt64(logic [RAD_W-1:0] x);
            logic [ROOT_W-1:0] r;
            logic [ROOT_W-1:0] cand;
            logic [RAD_W-1:0]  sq;
            r = '0;
            for (int b = ROOT_W - 1; b >= 0; b--) begin
                cand = r | (ROOT_W'(1) << b);
                sq   = RAD_W'(cand) * RAD_W'(cand);
                if (sq <= x)
                    r = cand;
            end
            return r;
        endfunction

        function void note_radicand(logic [RAD_W-1:0] x);
            expected_roots.push_back(floor_sqrt64(x));
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_root(logic [ROOT_W-1:0] got);
            logic [ROOT_W-1:0] want;
            if (expected_roots.size() == 0) begin
                report_mismatch($sformatf("root %0d arrived with no item pending", got));
            end
            else begin
                want = expected_roots.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("root is %0d, expected %0d", got, want));
            end
        endtask

        function int pending();
            return expected_roots.size();
        endfunction

        task check_drained();
            if (expected_roots.size() != 0)
                report_mismatch($sformatf("%0d roots never arrived", expected_roots.size()));
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [RAD_W-1:0]  radicand;
    logic              out_valid;
    logic              out_ready;
    logic [ROOT_W-1:0] root;

    sqrt_scoreboard sb = new();

    // Percent chance, per cycle, that the sender holds back or the receiver stalls.
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int cycle_count     = 0;

    integer_square_root_64_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .radicand  (radicand),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .root      (root)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Everything is sampled at the rising edge, before any of this edge's
    // nonblocking updates land, so the order of processes within the step
    // does not matter. An input item is noted before a result is checked.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_radicand(radicand);
            if (out_valid && out_ready)
                sb.check_root(root);
        end
    end

    // The receiver draws a fresh ready every cycle; with a zero stall rate it
    // simply keeps ready high.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d roots pending",
                     cycle_count, sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Picks a radicand from a mix of shapes: full-width noise, values of every
    // magnitude, and the neighborhood of perfect squares where an off-by-one
    // root would show up.
    function automatic logic [RAD_W-1:0] pick_radicand();
        logic [RAD_W-1:0]  v;
        logic [RAD_W-1:0]  rw;
        logic [ROOT_W-1:0] r;
        int                kind;
        kind = $urandom_range(9);
        v    = {$urandom, $urandom};
        r    = $urandom;
        case (kind)
            3, 4: v = v >> $urandom_range(63);
            5: begin
                rw = RAD_W'(r);
                v  = rw * rw;
            end
            6: begin
                // One below a square; a zero root wraps round to all ones.
                rw = RAD_W'(r);
                v  = rw * rw - 1;
            end
            7: begin
                // The largest radicand that still has root r.
                rw = RAD_W'(r);
                v  = rw * rw + 2 * rw;
            end
            8: v = RAD_W'($urandom_range(300));
            9: begin
                rw = RAD_W'(r >> $urandom_range(31));
                v  = rw * rw + RAD_W'($urandom_range(1));
            end
            default: ;
        endcase
        return v;
    endfunction

    // Offers one item, with random gaps ahead of it, and returns at the edge
    // where it is taken. Valid is left high so that a following item can be
    // offered in the very next cycle. While idle the payload carries noise.
    task automatic send_radicand(input logic [RAD_W-1:0] x);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            radicand <= {$urandom, $urandom};
            @(posedge clk);
        end
        in_valid <= 1'b1;
        radicand <= x;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Holds the sender off until the core has handed back every root it owes.
    // The first edge lets the monitor note the item that was just taken.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [RAD_W-1:0] corner_cases [0:21];
        int               send_pcts   [0:3];
        int               stall_pcts  [0:3];

        corner_cases = '{
            64'h0000_0000_0000_0000,    // zero
            64'h0000_0000_0000_0001,    // one to three all give one
            64'h0000_0000_0000_0002,
            64'h0000_0000_0000_0003,
            64'h0000_0000_0000_0004,
            64'h0000_0000_0000_0008,
            64'h0000_0000_0000_000F,
            64'h0000_0000_0000_0010,
            64'h0000_0000_0000_0011,
            64'h0000_0000_FFFF_FFFF,
            64'h0000_0001_0000_0000,
            64'h4000_0000_0000_0000,
            64'h3FFF_FFFF_FFFF_FFFF,
            64'h8000_0000_0000_0000,
            64'h7FFF_FFFF_FFFF_FFFF,
            64'hAAAA_AAAA_AAAA_AAAA,
            64'h5555_5555_5555_5555,
            64'hFFFF_FFFE_0000_0001,    // square of the largest root
            64'hFFFF_FFFE_0000_0000,
            64'hFFFF_FFFF_FFFF_FFFE,
            64'hFFFF_FFFF_FFFF_FFFF,    // largest radicand
            64'h0000_0000_0000_0000
        };
        send_pcts  = '{0, 49, 0, 11};
        stall_pcts = '{0, 0, 49, 11};

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        radicand  = '0;
        out_ready = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = send_pcts[ph];
            recv_stall_pct  = stall_pcts[ph];
            // The corner values go first, back to back, so every one of them
            // also meets the core at full rate.
            if (ph == 0) begin
                foreach (corner_cases[i])
                    send_radicand(corner_cases[i]);
            end
            for (int n = 0; n < ITEMS_A_PHASE; n++) begin
                send_radicand(pick_radicand());
                // Halfway through the first idling phase the core is allowed
                // to run completely dry once before traffic resumes.
                if (ph == 1 && n == ITEMS_A_PHASE / 2)
                    wait_for_drain();
            end
            wait_for_drain();
        end

        // Any stray result in the quiet tail is caught as unexpected.
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.check_drained();

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
